>>> rtl/rmof_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling median outlier filter package
// Shared constants, register map and controller states.
// ----------------------------------------------------------------------------
package rmof_pkg;

    // Reset contents of every history entry and of the threshold register.
    localparam int unsigned RESET_HEIGHT    = 800;
    localparam logic [15:0] RESET_THRESHOLD = 16'd600;
    localparam logic        RESET_ENABLE    = 1'b1;

    localparam int THRESH_BITS = 16;
    localparam int ADDR_BITS   = 3;

    // Register indexes on the configuration port.
    typedef enum logic {
        REG_THRESHOLD = 1'b0,
        REG_ENABLE    = 1'b1
    } t_reg_index;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } t_state;

endpackage

>>> rtl/rmof_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling median outlier filter sorted cell
// One entry of the sorted history. On an update the cells drop the oldest
// value and insert the stored value, each cell looking only at its neighbors.
// ----------------------------------------------------------------------------
module rmof_cell #(
    parameter int   HEIGHT_BITS = 16,
    parameter logic LAST        = 1'b0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_update,
    input  logic [HEIGHT_BITS-1:0] i_sample,
    input  logic [HEIGHT_BITS-1:0] i_oldest,
    input  logic [HEIGHT_BITS-1:0] i_stored,
    input  logic [HEIGHT_BITS-1:0] i_upper,
    input  logic [HEIGHT_BITS-1:0] i_below_c,
    input  logic                   i_below_lt,
    output logic [HEIGHT_BITS-1:0] o_value,
    output logic [HEIGHT_BITS-1:0] o_c,
    output logic                   o_lt,
    output logic                   o_sample_gt
);
    import rmof_pkg::*;

    logic [HEIGHT_BITS-1:0] r_value;
    logic [HEIGHT_BITS-1:0] n_value;
    logic [HEIGHT_BITS-1:0] w_c;
    logic                   w_lt;

    // Once the oldest value has been passed, the entry above slides down.
    assign w_c  = (r_value >= i_oldest) ? i_upper : r_value;
    assign w_lt = LAST ? 1'b1 : (w_c > i_stored);

    always_comb begin
        if (!w_lt) begin
            n_value = w_c;
        end else if (i_below_lt) begin
            n_value = i_below_c;
        end else begin
            n_value = i_stored;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= HEIGHT_BITS'(RESET_HEIGHT);
        end else if (i_update) begin
            r_value <= n_value;
        end
    end

    assign o_value     = r_value;
    assign o_c         = w_c;
    assign o_lt        = w_lt;
    assign o_sample_gt = r_value > i_sample;

endmodule

>>> rtl/rmof_history.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling median outlier filter arrival-order history
// Shift line of stored heights in arrival order; the oldest sits at tap 0.
// ----------------------------------------------------------------------------
module rmof_history #(
    parameter int DEPTH       = 39,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [HEIGHT_BITS-1:0] i_value,
    output logic [HEIGHT_BITS-1:0] o_oldest
);
    import rmof_pkg::*;

    logic [HEIGHT_BITS-1:0] r_taps [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_taps[i] <= HEIGHT_BITS'(RESET_HEIGHT);
            end
        end else if (i_push) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_taps[i] <= r_taps[i+1];
            end
            r_taps[DEPTH-1] <= i_value;
        end
    end

    assign o_oldest = r_taps[0];

endmodule

>>> rtl/rolling_median_outlier_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling median outlier filter
// Each accepted item is followed by a single update pass over the sorted cell
// chain, which registers the result once the output register is free; no new
// item is taken until that pass is done.
// The median is picked from two cells at accept; the chain is updated in the
// update state, which stalls while the output register is still occupied.
// Synchronous active-low reset: history to 800, threshold 600, sensor on.
// ----------------------------------------------------------------------------
module rolling_median_outlier_filter #(
    parameter int WINDOW      = 40,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rmof_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // Input items
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [HEIGHT_BITS-1:0]          i_sample_height,
    input  logic [HEIGHT_BITS-1:0]          i_substitute_height,
    // Result items
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_is_outlier,
    output logic [HEIGHT_BITS-1:0]          o_window_median,
    output logic [HEIGHT_BITS-1:0]          o_stored_height
);
    import rmof_pkg::*;

    localparam int DEPTH  = WINDOW - 1;
    localparam int MID    = WINDOW / 2;
    localparam int CMP_W  = (HEIGHT_BITS > THRESH_BITS) ? HEIGHT_BITS : THRESH_BITS;

    t_state                 r_state;
    t_state                 n_state;
    logic [THRESH_BITS-1:0] r_threshold;
    logic                   r_enable;
    logic [HEIGHT_BITS-1:0] r_sample;
    logic [HEIGHT_BITS-1:0] r_subst;
    logic [HEIGHT_BITS-1:0] r_median;
    logic                   r_out_valid;
    logic                   r_is_outlier;
    logic [HEIGHT_BITS-1:0] r_out_median;
    logic [HEIGHT_BITS-1:0] r_stored;

    logic                   w_in_accept;
    logic                   w_update;
    logic                   w_cfg_write;
    logic [HEIGHT_BITS-1:0] w_median;
    logic [HEIGHT_BITS-1:0] w_dist;
    logic                   w_outlier;
    logic [HEIGHT_BITS-1:0] w_stored;
    logic [HEIGHT_BITS-1:0] w_oldest;

    logic [HEIGHT_BITS-1:0] w_value [DEPTH];
    logic [HEIGHT_BITS-1:0] w_c     [DEPTH];
    logic                   w_lt    [DEPTH];
    logic                   w_gt    [DEPTH];

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= RESET_THRESHOLD;
            r_enable    <= RESET_ENABLE;
        end else if (w_cfg_write) begin
            unique case (t_reg_index'(paddr[2]))
                REG_THRESHOLD: r_threshold <= pwdata[THRESH_BITS-1:0];
                REG_ENABLE:    r_enable    <= pwdata[0];
                default:       r_enable    <= r_enable;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_index'(paddr[2]))
            REG_THRESHOLD: prdata = {{(32-THRESH_BITS){1'b0}}, r_threshold};
            REG_ENABLE:    prdata = {31'd0, r_enable};
            default:       prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sorted cell chain and arrival-order history
    // ------------------------------------------------------------------
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [HEIGHT_BITS-1:0] w_upper;
            logic [HEIGHT_BITS-1:0] w_below_c;
            logic                   w_below_lt;

            if (g == DEPTH - 1) begin : g_top
                assign w_upper = w_value[g];
            end else begin : g_mid
                assign w_upper = w_value[g+1];
            end

            if (g == 0) begin : g_bottom
                assign w_below_c  = '0;
                assign w_below_lt = 1'b0;
            end else begin : g_inner
                assign w_below_c  = w_c[g-1];
                assign w_below_lt = w_lt[g-1];
            end

            rmof_cell #(
                .HEIGHT_BITS (HEIGHT_BITS),
                .LAST        ((g == DEPTH - 1) ? 1'b1 : 1'b0)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_update    (w_update),
                .i_sample    (i_sample_height),
                .i_oldest    (w_oldest),
                .i_stored    (w_stored),
                .i_upper     (w_upper),
                .i_below_c   (w_below_c),
                .i_below_lt  (w_below_lt),
                .o_value     (w_value[g]),
                .o_c         (w_c[g]),
                .o_lt        (w_lt[g]),
                .o_sample_gt (w_gt[g])
            );
        end
    endgenerate

    rmof_history #(
        .DEPTH       (DEPTH),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_history (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_update),
        .i_value  (w_stored),
        .o_oldest (w_oldest)
    );

    // The sample would land at the middle position, below it, or above it;
    // the two cells around the middle settle which value ends up there.
    always_comb begin
        if (!w_gt[MID]) begin
            w_median = w_value[MID];
        end else if (w_gt[MID-1]) begin
            w_median = w_value[MID-1];
        end else begin
            w_median = i_sample_height;
        end
    end

    assign w_dist    = (r_sample > r_median) ? (r_sample - r_median) : (r_median - r_sample);
    assign w_outlier = CMP_W'(w_dist) > CMP_W'(r_threshold);
    assign w_stored  = (!w_outlier && r_enable) ? r_sample : r_subst;

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    assign w_in_accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_update   = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_in_ready = 1'b1;
            ST_UPDATE: w_update   = !r_out_valid || i_out_ready;
            default:   o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_update) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The median is copied into the output register at update, so a new
    // item can be taken while the previous result still waits.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_sample <= i_sample_height;
            r_subst  <= i_substitute_height;
            r_median <= w_median;
        end
        if (w_update) begin
            r_is_outlier <= w_outlier;
            r_out_median <= r_median;
            r_stored     <= w_stored;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_is_outlier    = r_is_outlier;
    assign o_window_median = r_out_median;
    assign o_stored_height = r_stored;

endmodule

>>> dv/tb_rolling_median_outlier_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling median outlier filter testbench
// Drives height samples through the valid/ready input with random gaps and
// receiver stalls, and programs the threshold and enable registers over APB
// between phases. A scoreboard keeps its own copy of the height history,
// computes the upper median, the outlier flag and the stored height for every
// accepted item, and compares them with each result in order.
// ----------------------------------------------------------------------------
module tb_rolling_median_outlier_filter;
    import rmof_pkg::*;

    localparam int MEDIAN_WINDOW  = 40;
    localparam int HISTORY_DEPTH  = MEDIAN_WINDOW - 1;
    localparam int PHASE_ITEMS    = 175;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_RESULT = 600;
    localparam int QUIET_LIMIT    = 2000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic        outlier;
        logic [15:0] median;
        logic [15:0] stored;
    } t_filter_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_sample_height;
    logic [15:0] i_substitute_height;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_is_outlier;
    logic [15:0] o_window_median;
    logic [15:0] o_stored_height;

    rolling_median_outlier_filter uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_sample_height     (i_sample_height),
        .i_substitute_height (i_substitute_height),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_is_outlier        (o_is_outlier),
        .o_window_median     (o_window_median),
        .o_stored_height     (o_stored_height)
    );

    class height_scoreboard;
        logic [15:0]    history [HISTORY_DEPTH];
        logic [15:0]    threshold;
        logic           enabled;
        t_filter_result expected_q [$];
        int             errors;

        function new();
            foreach (history[k]) history[k] = 16'(RESET_HEIGHT);
            threshold = RESET_THRESHOLD;
            enabled   = RESET_ENABLE;
            errors    = 0;
        endfunction

        // Insertion sort of the stored history plus the new sample.
        function logic [15:0] upper_median(logic [15:0] sample);
            logic [15:0] sorted [MEDIAN_WINDOW];
            logic [15:0] v;
            int          j;
            for (int i = 0; i < MEDIAN_WINDOW; i++) begin
                v = (i < HISTORY_DEPTH) ? history[i] : sample;
                j = i;
                while (j > 0 && sorted[j-1] > v) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = v;
            end
            return sorted[MEDIAN_WINDOW/2];
        endfunction

        function void note_input(logic [15:0] sample, logic [15:0] substitute);
            t_filter_result r;
            logic [15:0]    distance;
            r.median  = upper_median(sample);
            distance  = (sample > r.median) ? sample - r.median : r.median - sample;
            r.outlier = distance > threshold;
            r.stored  = (!r.outlier && enabled) ? sample : substitute;
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) history[i] = history[i+1];
            history[HISTORY_DEPTH-1] = r.stored;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic outlier, logic [15:0] median, logic [15:0] stored);
            t_filter_result r;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result: outlier=%0d median=%0d stored=%0d",
                             outlier, median, stored);
                return;
            end
            r = expected_q.pop_front();
            if (outlier !== r.outlier || median !== r.median || stored !== r.stored) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             r.outlier, r.median, r.stored, outlier, median, stored);
            end
        endfunction
    endclass

    height_scoreboard sb;
    bit               steady;
    int               level;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit take_gap();
        return !steady && ($urandom_range(99) < 36);
    endfunction

    function automatic logic [15:0] clamp_height(int v);
        if (v < 0) return 16'd0;
        if (v > 65535) return 16'hFFFF;
        return 16'(v);
    endfunction

    // Valid stays high from one item to the next unless a gap is taken.
    task automatic send_item(input logic [15:0] sample, input logic [15:0] substitute);
        while (take_gap()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_sample_height     <= sample;
        i_substitute_height <= substitute;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(sample, substitute);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_THRESHOLD)
            sb.threshold = data[15:0];
        else
            sb.enabled = data[0];
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Upper register bits carry junk; only the low bits must take effect.
    task automatic configure(input logic [15:0] thr, input logic en);
        drain();
        write_reg(REG_THRESHOLD, {16'($urandom), thr});
        write_reg(REG_ENABLE, {31'($urandom), en});
    endtask

    // Mostly samples near a drifting level, with spikes, extremes and steps.
    task automatic send_random(input int count, input int spread);
        int pick;
        int v;
        for (int n = 0; n < count; n++) begin
            pick  = $urandom_range(99);
            level = level + int'($urandom_range(40)) - 20;
            if (pick < 5) level = $urandom_range(65535);
            level = clamp_height(level);
            if (pick < 70)
                v = level + int'($urandom_range(2 * spread)) - spread;
            else if (pick < 88)
                v = $urandom_range(65535);
            else
                v = (pick < 94) ? 0 : 65535;
            send_item(clamp_height(v),
                      $urandom_range(1) ? clamp_height(level + int'($urandom_range(63)) - 32)
                                        : 16'($urandom));
        end
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        i_in_valid          <= 1'b0;
        i_sample_height     <= '0;
        i_substitute_height <= '0;
        steady = 1'b0;
        level  = RESET_HEIGHT;
        sb     = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: median starts at 800, so 1400 sits exactly on the
        // threshold and 1401 is just past it.
        send_item(16'd800, 16'd0);
        send_item(16'd1400, 16'hFFFF);
        send_item(16'd1401, 16'd900);
        send_item(16'd200, 16'd850);
        send_item(16'd199, 16'd810);
        send_item(16'd0, 16'hFFFF);
        send_item(16'hFFFF, 16'd0);
        send_item(16'd800, 16'h5A5A);

        // Zero threshold: any distance from the median is rejected.
        configure(16'd0, 1'b1);
        send_item(16'd800, 16'd1);
        send_item(16'd801, 16'd800);
        send_item(16'd799, 16'd800);
        send_item(16'd800, 16'hA5A5);

        // Sensor off: nothing is an outlier, but the substitute is stored.
        configure(16'hFFFF, 1'b0);
        send_item(16'd0, 16'hFFFF);
        send_item(16'hFFFF, 16'd0);
        send_item(16'd1234, 16'hA5A5);

        configure(16'd1, 1'b0);
        send_item(16'd800, 16'd800);
        send_item(16'd802, 16'd801);

        configure(16'd600, 1'b1);
        send_random(PHASE_ITEMS, 1200);

        configure(16'd0, 1'b1);
        steady = 1'b1;
        send_random(PHASE_ITEMS, 4);
        steady = 1'b0;

        configure(16'($urandom_range(2000)), 1'b0);
        send_random(PHASE_ITEMS, 1500);

        configure(16'hFFFF, 1'b1);
        send_random(PHASE_ITEMS, 3000);

        configure(16'($urandom), 1'($urandom));
        send_random(PHASE_ITEMS, 20000);

        configure(16'($urandom_range(300, 1)), 1'b1);
        send_random(PHASE_ITEMS, 500);

        drain();
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("tb_rolling_median_outlier_filter: done, clean");
        end else begin
            $display("tb_rolling_median_outlier_filter: done, errors");
        end
        $finish;
    end

    // Result side: random stalls, plus one long hold-off so the block backs up.
    initial begin
        int hold_left;
        int results;
        hold_left = 0;
        results   = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                sb.check_result(o_is_outlier, o_window_median, o_stored_height);
                results++;
                if (results == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= !take_gap();
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel)
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("tb_rolling_median_outlier_filter: done, errors");
                $finish;
            end
        end
    end

endmodule
